@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rswr_pkg.sv @@
// ---------------------------------------------------------------------------
// rswr_pkg
// Types, widths, register indexes and codes of the sampling block.
// ---------------------------------------------------------------------------
`default_nettype none

package rswr_pkg;

    localparam int POOL_DEPTH_DEFAULT  = 256;
    localparam int RANDOM_BITS_DEFAULT = 15;

    localparam int SIZE_W      = 9;
    localparam int COUNT_W     = 9;
    localparam int OFFSET_W    = 16;
    localparam int ELEMENT_W   = 17;
    localparam int STATUS_W    = 2;
    localparam int GRANTED_W   = 9;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_POOL_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DRAW_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_OFFSET = 2'd2;

    localparam logic [SIZE_W-1:0]   POOL_SIZE_RESET   = 9'd256;
    localparam logic [COUNT_W-1:0]  DRAW_COUNT_RESET  = 9'd1;
    localparam logic [OFFSET_W-1:0] BASE_OFFSET_RESET = 16'd0;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ALL  = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0]   pool_size;
        logic [COUNT_W-1:0]  draw_count;
        logic [OFFSET_W-1:0] base_offset;
    } cfg_t;

    typedef struct packed {
        logic [ELEMENT_W-1:0] element;
        logic                 last;
        logic [STATUS_W-1:0]  status;
        logic [GRANTED_W-1:0] granted;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INDEX,
        ST_FETCH,
        ST_SHIFT,
        ST_FINISH,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ design/rswr_ram.sv @@
// ---------------------------------------------------------------------------
// rswr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module rswr_ram #(
    parameter int WIDTH = $clog2(rswr_pkg::POOL_DEPTH_DEFAULT),
    parameter int DEPTH = rswr_pkg::POOL_DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/rswr_cfg.sv @@
// ---------------------------------------------------------------------------
// rswr_cfg
// Configuration registers; flags a pool refill on a size or count write.
// ---------------------------------------------------------------------------
`default_nettype none

module rswr_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rswr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rswr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output rswr_pkg::cfg_t                           cfg,
    output logic                                     cfg_refill
);

    logic [rswr_pkg::SIZE_W-1:0]   pool_size_reg;
    logic [rswr_pkg::COUNT_W-1:0]  draw_count_reg;
    logic [rswr_pkg::OFFSET_W-1:0] base_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg   <= rswr_pkg::POOL_SIZE_RESET;
            draw_count_reg  <= rswr_pkg::DRAW_COUNT_RESET;
            base_offset_reg <= rswr_pkg::BASE_OFFSET_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rswr_pkg::REG_POOL_SIZE: begin
                    pool_size_reg <= cfg_wdata[rswr_pkg::SIZE_W-1:0];
                end
                rswr_pkg::REG_DRAW_COUNT: begin
                    draw_count_reg <= cfg_wdata[rswr_pkg::COUNT_W-1:0];
                end
                rswr_pkg::REG_BASE_OFFSET: begin
                    base_offset_reg <= cfg_wdata[rswr_pkg::OFFSET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg_refill = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index) inside
                rswr_pkg::REG_POOL_SIZE, rswr_pkg::REG_DRAW_COUNT: begin
                    cfg_refill = 1'b1;
                end
                default: begin
                    cfg_refill = 1'b0;
                end
            endcase
        end
    end

    assign cfg.pool_size   = pool_size_reg;
    assign cfg.draw_count  = draw_count_reg;
    assign cfg.base_offset = base_offset_reg;

endmodule

`default_nettype wire

@@ design/rswr_ctrl.sv @@
// ---------------------------------------------------------------------------
// rswr_ctrl
// Draw sequencer: scales the random word, reads the chosen pool entry and
// closes the gap by moving the entries above it down, one per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rswr_ctrl #(
    parameter int POOL_DEPTH  = rswr_pkg::POOL_DEPTH_DEFAULT,
    parameter int RANDOM_BITS = rswr_pkg::RANDOM_BITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rswr_pkg::cfg_t                cfg,
    input  wire logic                          cfg_refill,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [RANDOM_BITS-1:0]        s_random_value,
    input  wire logic                          s_restart,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output rswr_pkg::result_t                  res,
    output logic                               mem_we,
    output logic [$clog2(POOL_DEPTH)-1:0]      mem_waddr,
    output logic [$clog2(POOL_DEPTH)-1:0]      mem_wdata,
    output logic [$clog2(POOL_DEPTH)-1:0]      mem_raddr,
    input  wire logic [$clog2(POOL_DEPTH)-1:0] mem_rdata
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int PW = RANDOM_BITS + CW;
    localparam int NW = (CW > rswr_pkg::SIZE_W) ? CW : rswr_pkg::SIZE_W;
    localparam int EW = rswr_pkg::ELEMENT_W;
    localparam int GW = rswr_pkg::GRANTED_W;

    rswr_pkg::state_t  state_reg, state_next;
    logic [RANDOM_BITS-1:0] rnd_reg, rnd_next;
    logic              fresh_reg, fresh_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     picks_reg, picks_next;
    logic              dirty_reg, dirty_next;
    logic [AW-1:0]     lo_reg, lo_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic              rd_ident_reg, rd_ident_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    rswr_pkg::result_t res_reg, res_next;

    logic [NW-1:0] size_x;
    logic [NW-1:0] draw_x;
    logic [CW-1:0] eff_pool;
    logic [CW-1:0] rem_e;
    logic [CW-1:0] picks_e;
    logic          dirty_e;
    logic          need_refill;
    logic [CW-1:0] rem_u;
    logic [CW-1:0] picks_u;
    logic          dirty_u;
    logic [CW-1:0] pos;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] idx_full;
    logic [CW-1:0] idx_clamp;
    logic [AW-1:0] idx_sel;
    logic [CW-1:0] picks_inc;
    logic [AW-1:0] ptr_addr;
    logic          issue_ident;
    logic [AW-1:0] rd_value;
    logic          more;

    assign size_x = NW'(cfg.pool_size);
    assign draw_x = NW'(cfg.draw_count);

    always_comb begin
        if (cfg.pool_size == '0) begin
            eff_pool = CW'(1);
        end else if (size_x > NW'(POOL_DEPTH)) begin
            eff_pool = CW'(POOL_DEPTH);
        end else begin
            eff_pool = CW'(cfg.pool_size);
        end
    end

    assign rem_e   = fresh_reg ? eff_pool : rem_reg;
    assign picks_e = fresh_reg ? '0 : picks_reg;
    assign dirty_e = fresh_reg ? 1'b0 : dirty_reg;

    assign need_refill = (rem_e == '0) || (rem_e > eff_pool) || (NW'(picks_e) >= draw_x);
    assign rem_u   = need_refill ? eff_pool : rem_e;
    assign picks_u = need_refill ? '0 : picks_e;
    assign dirty_u = need_refill ? 1'b0 : dirty_e;

    assign pos     = (picks_e >= eff_pool) ? '0 : picks_e;
    assign pos_inc = pos + CW'(1);

    assign idx_full  = prod_reg[RANDOM_BITS +: CW];
    assign idx_clamp = (idx_full >= rem_reg) ? (rem_reg - CW'(1)) : idx_full;
    assign idx_sel   = idx_clamp[AW-1:0];

    assign picks_inc   = picks_reg + CW'(1);
    assign ptr_addr    = ptr_reg[AW-1:0];
    assign issue_ident = !(dirty_reg && (ptr_addr >= lo_reg));
    assign more        = (ptr_reg < rem_reg);

    // entries outside the written span still hold their refill value
    assign rd_value = rd_ident_reg ? rd_addr_reg : mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rswr_pkg::ST_IDLE;
            fresh_reg <= 1'b1;
            dirty_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fresh_reg <= fresh_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge aclk) begin
        rnd_reg      <= rnd_next;
        rem_reg      <= rem_next;
        picks_reg    <= picks_next;
        lo_reg       <= lo_next;
        prod_reg     <= prod_next;
        idx_reg      <= idx_next;
        ptr_reg      <= ptr_next;
        rd_ident_reg <= rd_ident_next;
        rd_addr_reg  <= rd_addr_next;
        res_reg      <= res_next;
    end

    always_comb begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        fresh_next    = fresh_reg;
        rem_next      = rem_reg;
        picks_next    = picks_reg;
        dirty_next    = dirty_reg;
        lo_next       = lo_reg;
        prod_next     = prod_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        rd_ident_next = rd_ident_reg;
        rd_addr_next  = rd_addr_reg;
        res_next      = res_reg;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = rd_addr_reg - AW'(1);
        mem_wdata     = rd_value;
        mem_raddr     = ptr_addr;

        unique case (state_reg)
            rswr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    rnd_next = s_random_value;
                    if (s_restart) begin
                        fresh_next = 1'b1;
                    end
                    state_next = rswr_pkg::ST_DECIDE;
                end
            end
            rswr_pkg::ST_DECIDE: begin
                res_next        = '0;
                res_next.status = rswr_pkg::STATUS_OK;
                if (cfg.draw_count == '0) begin
                    res_next.last   = 1'b1;
                    res_next.status = rswr_pkg::STATUS_NONE;
                    state_next      = rswr_pkg::ST_EMIT;
                end else if (draw_x >= NW'(eff_pool)) begin
                    res_next.status  = rswr_pkg::STATUS_ALL;
                    res_next.element = EW'(pos) + EW'(cfg.base_offset);
                    if (pos_inc >= eff_pool) begin
                        res_next.last    = 1'b1;
                        res_next.granted = GW'(eff_pool - CW'(1));
                        fresh_next       = 1'b1;
                    end else begin
                        fresh_next = 1'b0;
                        picks_next = pos_inc;
                        rem_next   = rem_e;
                        dirty_next = dirty_e;
                    end
                    state_next = rswr_pkg::ST_EMIT;
                end else begin
                    fresh_next = 1'b0;
                    rem_next   = rem_u;
                    picks_next = picks_u;
                    dirty_next = dirty_u;
                    prod_next  = PW'(rnd_reg) * PW'(rem_u);
                    state_next = rswr_pkg::ST_INDEX;
                end
            end
            rswr_pkg::ST_INDEX: begin
                mem_raddr     = idx_sel;
                rd_addr_next  = idx_sel;
                rd_ident_next = !(dirty_reg && (idx_sel >= lo_reg));
                idx_next      = idx_sel;
                ptr_next      = CW'(idx_sel) + CW'(1);
                state_next    = rswr_pkg::ST_FETCH;
            end
            rswr_pkg::ST_FETCH: begin
                res_next.element = EW'(rd_value) + EW'(cfg.base_offset);
                if (more) begin
                    rd_addr_next  = ptr_addr;
                    rd_ident_next = issue_ident;
                    ptr_next      = ptr_reg + CW'(1);
                    state_next    = rswr_pkg::ST_SHIFT;
                end else begin
                    state_next = rswr_pkg::ST_FINISH;
                end
            end
            rswr_pkg::ST_SHIFT: begin
                // move the entry read last cycle down one place
                mem_we = 1'b1;
                if (more) begin
                    rd_addr_next  = ptr_addr;
                    rd_ident_next = issue_ident;
                    ptr_next      = ptr_reg + CW'(1);
                end else begin
                    state_next = rswr_pkg::ST_FINISH;
                end
            end
            rswr_pkg::ST_FINISH: begin
                if (NW'(picks_inc) >= draw_x) begin
                    res_next.last    = 1'b1;
                    res_next.granted = cfg.draw_count;
                    fresh_next       = 1'b1;
                end else begin
                    rem_next   = rem_reg - CW'(1);
                    picks_next = picks_inc;
                    if ((CW'(idx_reg) + CW'(1)) < rem_reg) begin
                        dirty_next = 1'b1;
                        lo_next    = (dirty_reg && (lo_reg < idx_reg)) ? lo_reg : idx_reg;
                    end
                end
                state_next = rswr_pkg::ST_EMIT;
            end
            rswr_pkg::ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = rswr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rswr_pkg::ST_IDLE;
            end
        endcase

        if (cfg_refill) begin
            fresh_next = 1'b1;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ design/random_sample_without_replacement.sv @@
// ---------------------------------------------------------------------------
// random_sample_without_replacement
// Status-only and in-order results go from DECIDE straight to EMIT; a random
// pick passes DECIDE, INDEX, FETCH, SHIFT while entries lie above it, and
// FINISH; SHIFT moves one pool entry down per cycle. Results are registered.
// One item at a time: no new input is taken until the result leaves EMIT.
// Reset is synchronous, active low; the pool reads as 0..N-1 at once.
// ---------------------------------------------------------------------------
`default_nettype none

module random_sample_without_replacement #(
    parameter int POOL_DEPTH  = rswr_pkg::POOL_DEPTH_DEFAULT,
    parameter int RANDOM_BITS = rswr_pkg::RANDOM_BITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rswr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rswr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [RANDOM_BITS-1:0]            s_random_value,
    input  wire logic                              s_restart,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [rswr_pkg::ELEMENT_W-1:0]         m_element_value,
    output logic                                   m_last,
    output logic [rswr_pkg::STATUS_W-1:0]          m_status,
    output logic [rswr_pkg::GRANTED_W-1:0]         m_granted_count
);

    localparam int AW = $clog2(POOL_DEPTH);

    rswr_pkg::cfg_t    cfg;
    logic              cfg_refill;
    logic              res_valid;
    logic              res_ready;
    rswr_pkg::result_t res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [AW-1:0]     mem_rdata;

    logic              m_valid_reg;
    rswr_pkg::result_t m_res_reg;

    rswr_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg),
        .cfg_refill (cfg_refill)
    );

    rswr_ctrl #(
        .POOL_DEPTH  (POOL_DEPTH),
        .RANDOM_BITS (RANDOM_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cfg_refill     (cfg_refill),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_random_value (s_random_value),
        .s_restart      (s_restart),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    rswr_ram #(
        .WIDTH (AW),
        .DEPTH (POOL_DEPTH)
    ) u_pool_ram (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_element_value = m_res_reg.element;
    assign m_last          = m_res_reg.last;
    assign m_status        = m_res_reg.status;
    assign m_granted_count = m_res_reg.granted;

endmodule

`default_nettype wire

@@ design/rswr_checker.sv @@
// ---------------------------------------------------------------------------
// rswr_checker
// Port-level checks of the sampling block, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rswr_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [rswr_pkg::ELEMENT_W-1:0]    m_element_value,
    input wire logic                              m_last,
    input wire logic [rswr_pkg::STATUS_W-1:0]     m_status,
    input wire logic [rswr_pkg::GRANTED_W-1:0]    m_granted_count
);

    // one item in work at a time
    `ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while busy")

    `ASSERT_IMPLIES(a_none_result, aclk, aresetn, m_valid && (m_status == rswr_pkg::STATUS_NONE), m_last && (m_element_value == '0) && (m_granted_count == '0), "bad empty-draw result")

    `ASSERT_IMPLIES(a_mid_draw, aclk, aresetn, m_valid && !m_last, (m_granted_count == '0) && (m_status != rswr_pkg::STATUS_NONE), "bad mid-draw result")

    `ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_element_value) && $stable(m_last), "result changed under stall")

endmodule

bind random_sample_without_replacement rswr_checker u_rswr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_element_value (m_element_value),
    .m_last          (m_last),
    .m_status        (m_status),
    .m_granted_count (m_granted_count)
);

`default_nettype wire
